// ===== sv/rtt_pkg.sv =====
package rtt_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int OccW = $clog2(TableDepth + 1);

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_ACK   = 2'd1,
		ACT_SCAN  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_RESENT  = 3'd0,
		ST_DUE     = 3'd1,
		ST_DROPPED = 3'd2,
		ST_ADDED   = 3'd3,
		ST_FULL    = 3'd4,
		ST_REMOVED = 3'd5,
		ST_ANSWER  = 3'd6
	} status_t;

	localparam logic CFG_INTERVAL = 1'b0;
	localparam logic CFG_MAX_SENDS = 1'b1;

	typedef struct packed {
		action_t     action;
		logic [15:0] msg_id;
		logic [31:0] now;
		logic        link_up;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_id;
		logic [3:0]  send_count;
		logic [4:0]  removed_count;
		logic        last;
	} res_t;

endpackage

// ===== sv/rtt_front.sv =====
// Input stage: registers one command and holds it until the engine takes it.
module rtt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtt_pkg::cmd_t in_cmd,
	output logic          q_valid,
	input  logic          q_ready,
	output rtt_pkg::cmd_t q_cmd
);
	logic          full_q;
	rtt_pkg::cmd_t cmd_q;

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_cmd    = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_cmd;
		end
	end
endmodule

// ===== sv/rtt_engine.sv =====
// Table engine: walks the entries one per cycle unless a result waits for the output, compacting in place.
module rtt_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rtt_pkg::cmd_t cmd,
	input  logic [31:0]   retry_interval,
	input  logic [3:0]    max_sends,
	output logic          res_valid,
	input  logic          res_ready,
	output rtt_pkg::res_t res
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                      state_q;
	rtt_pkg::cmd_t               cmd_q;
	logic [rtt_pkg::OccW-1:0]    occ_q, rd_q, wr_q;
	logic [4:0]                  rem_q;
	logic [3:0]                  ans_q;
	logic                        full_add_q;
	logic [15:0]                 id_q   [rtt_pkg::TableDepth];
	logic [3:0]                  cnt_q  [rtt_pkg::TableDepth];
	logic [31:0]                 time_q [rtt_pkg::TableDepth];
	logic                        rv_q;
	rtt_pkg::res_t               res_q;

	logic [rtt_pkg::IdxW-1:0] ri, wi;
	logic [15:0] eid;
	logic [3:0]  ecnt, ncnt;
	logic [31:0] etime;
	logic        walk_end, drop, due, keep, emit, slot, res_load;

	assign ri    = rd_q[rtt_pkg::IdxW-1:0];
	assign wi    = wr_q[rtt_pkg::IdxW-1:0];
	assign eid   = id_q[ri];
	assign ecnt  = cnt_q[ri];
	assign etime = time_q[ri];
	assign walk_end = (rd_q == occ_q);
	assign drop  = (ecnt >= max_sends);
	assign due   = (cmd_q.action == rtt_pkg::ACT_SCAN) && !drop
		&& ((cmd_q.now - etime) > retry_interval);
	assign ncnt  = (ecnt == 4'd15) ? ecnt : ecnt + 4'd1;
	assign keep  = (cmd_q.action == rtt_pkg::ACT_ACK) ? (eid != cmd_q.msg_id)
		: (cmd_q.action == rtt_pkg::ACT_SCAN) ? !drop : 1'b1;
	assign emit  = (cmd_q.action == rtt_pkg::ACT_SCAN) && (drop || due);
	assign slot  = !rv_q || res_ready;
	assign res_load = (state_q == S_WALK && !walk_end && emit && slot)
		|| (state_q == S_DONE && slot);

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = rv_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			rv_q    <= 1'b0;
			rd_q    <= '0;
			wr_q    <= '0;
		end else begin
			if (res_load) begin
				rv_q <= 1'b1;
			end else if (res_ready) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						rd_q <= '0;
						wr_q <= '0;
						if (cmd.action == rtt_pkg::ACT_ADD) begin
							state_q <= S_DONE;
							if (occ_q != rtt_pkg::OccW'(rtt_pkg::TableDepth))
								occ_q <= occ_q + 1'b1;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (walk_end) begin
						occ_q <= wr_q;
						state_q <= (cmd_q.action == rtt_pkg::ACT_SCAN) ? S_IDLE : S_DONE;
					end else if (!emit || slot) begin
						rd_q <= rd_q + 1'b1;
						if (keep) wr_q <= wr_q + 1'b1;
					end
				end
				S_DONE: begin
					if (slot) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Scan results carry last when no later entry reports in the same scan.
	logic no_later;
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			rem_q <= '0;
			ans_q <= '0;
			full_add_q <= (occ_q == rtt_pkg::OccW'(rtt_pkg::TableDepth));
			if (cmd.action == rtt_pkg::ACT_ADD
					&& occ_q != rtt_pkg::OccW'(rtt_pkg::TableDepth)) begin
				id_q[occ_q[rtt_pkg::IdxW-1:0]]   <= cmd.msg_id;
				cnt_q[occ_q[rtt_pkg::IdxW-1:0]]  <= '0;
				time_q[occ_q[rtt_pkg::IdxW-1:0]] <= cmd.now;
			end
		end
		if (state_q == S_WALK && !walk_end && (!emit || slot)) begin
			if (keep) begin
				id_q[wi]   <= eid;
				cnt_q[wi]  <= due ? ncnt : ecnt;
				time_q[wi] <= due ? cmd_q.now : etime;
			end
			if (eid == cmd_q.msg_id) begin
				rem_q <= rem_q + 5'd1;
				ans_q <= ecnt;
			end
			if (emit) begin
				res_q.status <= drop ? rtt_pkg::ST_DROPPED
					: (cmd_q.link_up ? rtt_pkg::ST_RESENT : rtt_pkg::ST_DUE);
				res_q.out_id <= eid;
				res_q.send_count <= drop ? ecnt : ncnt;
				res_q.removed_count <= '0;
				res_q.last <= no_later;
			end
		end
		if (state_q == S_DONE && slot) begin
			res_q.out_id <= cmd_q.msg_id;
			res_q.last <= 1'b1;
			case (cmd_q.action)
				rtt_pkg::ACT_ADD: begin
					res_q.status <= full_add_q ? rtt_pkg::ST_FULL : rtt_pkg::ST_ADDED;
					res_q.send_count <= '0;
					res_q.removed_count <= '0;
				end
				rtt_pkg::ACT_ACK: begin
					res_q.status <= rtt_pkg::ST_REMOVED;
					res_q.send_count <= '0;
					res_q.removed_count <= rem_q;
				end
				default: begin
					res_q.status <= rtt_pkg::ST_ANSWER;
					res_q.send_count <= ans_q;
					res_q.removed_count <= '0;
				end
			endcase
		end
	end

	// no_later: true when no entry after the current one will report in this scan.
	logic [rtt_pkg::TableDepth-1:0] rep;
	always_comb begin
		for (int k = 0; k < rtt_pkg::TableDepth; k++) begin
			rep[k] = (cnt_q[k] >= max_sends) || ((cmd_q.now - time_q[k]) > retry_interval);
		end
	end
	always_comb begin
		no_later = 1'b1;
		for (int k = 0; k < rtt_pkg::TableDepth; k++) begin
			if (k > int'(rd_q) && k < int'(occ_q) && rep[k]) no_later = 1'b0;
		end
	end

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= rtt_pkg::OccW'(rtt_pkg::TableDepth)) else $error("occupancy overflow");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= rd_q) else $error("write pointer ahead of read");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK && walk_end |=> state_q == S_IDLE || state_q == S_DONE)
		else $error("walk exit");
endmodule

// ===== sv/retransmit_timer_table.sv =====
// Add answers via the engine's done state; ack and query walk the table first.
// Scan walks one entry per cycle, stalling on output backpressure.
// The engine takes a new item only when idle, so the table walk sets throughput.
// The input register accepts the next item while the walk runs.
// arst_n clears occupancy and all handshake state; config resets to 3000 / 3.
module retransmit_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // action[1:0], msg_id[17:2], now[49:18], link_up[50]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // status[2:0], out_id[18:3], send_count[22:19], removed_count[27:23]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	rtt_pkg::cmd_t in_cmd, q_cmd;
	rtt_pkg::res_t res;
	logic          q_valid, q_ready;
	logic [31:0]   interval_q;
	logic [3:0]    max_sends_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= 32'd3000;
			max_sends_q <= 4'd3;
		end else if (cfg_we) begin
			if (cfg_index == rtt_pkg::CFG_INTERVAL) interval_q <= cfg_wdata;
			if (cfg_index == rtt_pkg::CFG_MAX_SENDS) max_sends_q <= cfg_wdata[3:0];
		end
	end

	assign in_cmd.action  = rtt_pkg::action_t'(s_axis_tdata[1:0]);
	assign in_cmd.msg_id  = s_axis_tdata[17:2];
	assign in_cmd.now     = s_axis_tdata[49:18];
	assign in_cmd.link_up = s_axis_tdata[50];

	rtt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	rtt_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.retry_interval(interval_q), .max_sends(max_sends_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {4'd0, res.removed_count, res.send_count, res.out_id, res.status};
	assign m_axis_tlast = res.last;
endmodule
